>>> src/aia_pkg.sv
package aia_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int AW = 31;
    localparam int RW = 64;

    typedef enum logic [2:0] {
        MODE_ADD = 3'd0,
        MODE_SUB = 3'd1,
        MODE_MUL = 3'd2,
        MODE_UNI = 3'd3,
        MODE_INT = 3'd4
    } t_mode;

    typedef struct packed {
        logic [2:0]        mode;
        logic signed [31:0] a_min;
        logic signed [31:0] a_max;
        logic              a_open_low;
        logic              a_open_high;
        logic [30:0]       a_align;
        logic signed [31:0] b_min;
        logic signed [31:0] b_max;
        logic              b_open_low;
        logic              b_open_high;
        logic [30:0]       b_align;
    } t_in;

    typedef struct packed {
        logic signed [63:0] r_min;
        logic signed [63:0] r_max;
        logic               r_open_low;
        logic               r_open_high;
        logic [62:0]        r_align;
    } t_out;

    // Sign-extend the low OPERAND_WIDTH bits of a bound to 64 bits.
    function automatic logic signed [63:0] sext(input logic [31:0] v);
        logic [OPERAND_WIDTH-1:0] t;
        t = v[OPERAND_WIDTH-1:0];
        return 64'($signed(t));
    endfunction

endpackage

>>> src/aia_if.sv
interface aia_in_if;
    logic         valid;
    logic         ready;
    aia_pkg::t_in data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface aia_out_if;
    logic          valid;
    logic          ready;
    aia_pkg::t_out data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> src/aia_gcd.sv
// Binary gcd of two nonzero 31-bit values, one step per cycle.
module aia_gcd (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_x,
    input  logic [30:0] i_y,
    output logic        o_done,
    output logic [30:0] o_gcd
);
    logic [30:0] r_x, r_y;
    logic [4:0]  r_k;
    logic        r_busy;
    logic        r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_x    <= i_x;
                r_y    <= i_y;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_x == r_y) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else if (!r_x[0] && !r_y[0]) begin
                    r_x <= r_x >> 1;
                    r_y <= r_y >> 1;
                    r_k <= r_k + 5'd1;
                end else if (!r_x[0]) begin
                    r_x <= r_x >> 1;
                end else if (!r_y[0]) begin
                    r_y <= r_y >> 1;
                end else if (r_x > r_y) begin
                    r_x <= (r_x - r_y) >> 1;
                end else begin
                    r_y <= (r_y - r_x) >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_gcd  = r_x << r_k;
endmodule

>>> src/aia_div.sv
// Restoring divider, unsigned 64 by 63 bits, one quotient bit per cycle.
module aia_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [62:0] i_den,
    output logic        o_done,
    output logic [63:0] o_quo,
    output logic [63:0] o_rem
);
    logic [63:0] r_q;
    logic [63:0] r_r;
    logic [62:0] r_d;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_sh;

    assign w_sh = {r_r, r_q[63]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_q    <= i_num;
                r_r    <= '0;
                r_d    <= i_den;
                r_cnt  <= 7'd64;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (w_sh >= {2'b00, r_d}) begin
                    r_r <= 64'(w_sh - {2'b00, r_d});
                    r_q <= {r_q[62:0], 1'b1};
                end else begin
                    r_r <= w_sh[63:0];
                    r_q <= {r_q[62:0], 1'b0};
                end
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_q;
    assign o_rem  = r_r;
endmodule

>>> src/aligned_interval_alu.sv
// Aligned interval arithmetic unit.
// One input channel carries a word with the operation and two ranges
// (bounds, open-end flags and alignment); one output channel returns one
// result word per input word, holding the snapped result range.
// An input word is accepted only when the unit is idle and the output
// register is empty. The work runs under a small sequencer that shares
// one binary gcd unit, one 32x32 multiplier used four times for multiply,
// one 31x31 alignment multiplier, and one 64-bit bit-serial divider used
// for the lcm and for rounding each bounded end. The result word stays
// in the output register while the receiver stalls, and the next input
// word is taken once it has been delivered.
// Reset (synchronous, active low) returns the sequencer to idle and empties
// the output register; the data registers are not cleared and there is no clearing pass.
module aligned_interval_alu (
    input logic    i_clk,
    input logic    i_rst_n,
    aia_in_if.sink   in_ch,
    aia_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_IDLE, S_GCD, S_LCMD, S_MUL, S_PREP, S_DMIN, S_DMAX, S_FIN, S_OUT
    } t_state;

    t_state r_state;
    aia_pkg::t_in r_in;
    logic signed [63:0] r_amn, r_amx, r_bmn, r_bmx;
    logic signed [63:0] r_mn, r_mx, r_lov, r_hiv;
    logic r_lo, r_hi, r_snap;
    logic [62:0] r_al;
    logic [1:0] r_pi;
    logic [3:0] r_ps;
    aia_pkg::t_out r_out;
    logic r_dstart;

    logic [30:0] w_aal, w_bal;
    assign w_aal = (r_in.a_align == '0) ? 31'd1 : r_in.a_align;
    assign w_bal = (r_in.b_align == '0) ? 31'd1 : r_in.b_align;

    // The gcd unit starts at the accepting edge, so it takes the alignments
    // straight from the input word.
    logic [30:0] w_in_aal, w_in_bal;
    assign w_in_aal = (in_ch.data.a_align == '0) ? 31'd1 : in_ch.data.a_align;
    assign w_in_bal = (in_ch.data.b_align == '0) ? 31'd1 : in_ch.data.b_align;

    logic g_start, g_done;
    logic [30:0] g_res;
    aia_gcd u_gcd (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(g_start),
        .i_x(w_in_aal), .i_y(w_in_bal), .o_done(g_done), .o_gcd(g_res)
    );

    logic d_done;
    logic [63:0] d_num, d_quo, d_rem;
    logic [62:0] d_den;
    aia_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart),
        .i_num(d_num), .i_den(d_den), .o_done(d_done), .o_quo(d_quo), .o_rem(d_rem)
    );

    // Shared multiplier, one 32x32 product per cycle in S_MUL.
    logic signed [31:0] w_ma, w_mb;
    logic signed [63:0] w_prod;
    always_comb begin
        w_ma = r_pi[1] ? r_amx[31:0] : r_amn[31:0];
        w_mb = r_pi[0] ? r_bmx[31:0] : r_bmn[31:0];
    end
    assign w_prod = 64'(w_ma) * 64'(w_mb);
    logic signed [63:0] r_prod;
    logic r_pv;
    logic [1:0] r_ppi;

    // Alignment product: a times b for multiply, (a / gcd) times b for the lcm.
    logic [30:0] w_alx;
    logic [61:0] w_alprod;
    assign w_alx = (r_state == S_LCMD) ? d_quo[30:0] : w_aal;
    assign w_alprod = {31'd0, w_alx} * {31'd0, w_bal};

    logic w_a_zero, w_b_zero, w_a_np, w_b_np, w_a_nn, w_b_nn;
    assign w_a_zero = !r_in.a_open_low && !r_in.a_open_high && r_amn == 0 && r_amx == 0;
    assign w_b_zero = !r_in.b_open_low && !r_in.b_open_high && r_bmn == 0 && r_bmx == 0;
    assign w_a_np = !r_in.a_open_high && r_amx <= 0;
    assign w_b_np = !r_in.b_open_high && r_bmx <= 0;
    assign w_a_nn = !r_in.a_open_low && r_amn >= 0;
    assign w_b_nn = !r_in.b_open_low && r_bmn >= 0;

    // Division operands: a's alignment over the gcd for the lcm, else the magnitude of the bound being rounded.
    logic signed [63:0] w_v;
    assign w_v = (r_state == S_DMIN) ? r_mn : r_mx;
    assign d_num = (r_state == S_LCMD) ? {33'd0, w_aal}
                 : (w_v < 0 ? 64'(-w_v) : w_v);
    assign d_den = (r_state == S_LCMD) ? {32'd0, g_res} : r_al;

    logic signed [63:0] w_up, w_dn;
    // Rounded values: truncated quotient times alignment, then adjusted.
    logic signed [63:0] w_qa;
    assign w_qa = w_v - $signed((w_v < 0) ? 64'(-d_rem) : d_rem);
    assign w_up = (d_rem == 0) ? w_v : (w_v >= 0 ? w_qa + $signed({1'b0, r_al}) : w_qa);
    assign w_dn = (d_rem == 0) ? w_v : (w_v < 0 ? w_qa - $signed({1'b0, r_al}) : w_qa);

    assign g_start = (r_state == S_IDLE) && in_ch.valid;
    assign in_ch.ready = (r_state == S_IDLE);
    assign out_ch.valid = (r_state == S_OUT);
    assign out_ch.data = r_out;

    logic [63:0] w_m64;
    assign w_m64 = (r_mn < 0) ? 64'(-r_mn) : r_mn;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dstart <= 1'b0;
        end else begin
            r_dstart <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_in  <= in_ch.data;
                        r_amn <= aia_pkg::sext(in_ch.data.a_min);
                        r_amx <= aia_pkg::sext(in_ch.data.a_max);
                        r_bmn <= aia_pkg::sext(in_ch.data.b_min);
                        r_bmx <= aia_pkg::sext(in_ch.data.b_max);
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (g_done) begin
                        r_al <= {32'd0, g_res};
                        unique case (r_in.mode)
                            aia_pkg::MODE_ADD: begin
                                r_lo <= r_in.a_open_low || r_in.b_open_low;
                                r_hi <= r_in.a_open_high || r_in.b_open_high;
                                r_mn <= r_amn + r_bmn;
                                r_mx <= r_amx + r_bmx;
                                r_state <= S_PREP;
                            end
                            aia_pkg::MODE_SUB: begin
                                r_lo <= r_in.a_open_low || r_in.b_open_high;
                                r_hi <= r_in.a_open_high || r_in.b_open_low;
                                r_mn <= r_amn - r_bmx;
                                r_mx <= r_amx - r_bmn;
                                r_state <= S_PREP;
                            end
                            aia_pkg::MODE_MUL: begin
                                r_al <= {1'b0, w_alprod};
                                r_pi <= 2'd0;
                                r_pv <= 1'b0;
                                r_lov <= 64'h7FFF_FFFF_FFFF_FFFF;
                                r_hiv <= 64'h8000_0000_0000_0000;
                                r_ps <= {r_in.a_open_high || r_in.b_open_high,
                                         r_in.a_open_high || r_in.b_open_low,
                                         r_in.a_open_low || r_in.b_open_high,
                                         r_in.a_open_low || r_in.b_open_low};
                                r_state <= S_MUL;
                            end
                            aia_pkg::MODE_UNI: begin
                                r_lo <= r_in.a_open_low && r_in.b_open_low;
                                r_hi <= r_in.a_open_high && r_in.b_open_high;
                                r_mn <= r_in.a_open_low ? r_bmn : (r_in.b_open_low ? r_amn
                                        : (r_amn > r_bmn ? r_amn : r_bmn));
                                r_mx <= r_in.a_open_high ? r_bmx : (r_in.b_open_high ? r_amx
                                        : (r_amx < r_bmx ? r_amx : r_bmx));
                                r_dstart <= 1'b1;
                                r_state <= S_LCMD;
                            end
                            aia_pkg::MODE_INT: begin
                                r_lo <= r_in.a_open_low || r_in.b_open_low;
                                r_hi <= r_in.a_open_high || r_in.b_open_high;
                                r_mn <= r_amn < r_bmn ? r_amn : r_bmn;
                                r_mx <= r_amx > r_bmx ? r_amx : r_bmx;
                                r_state <= S_PREP;
                            end
                            default: begin
                                r_lo <= 1'b1;
                                r_hi <= 1'b1;
                                r_al <= 63'd1;
                                r_state <= S_PREP;
                            end
                        endcase
                    end
                end
                S_LCMD: begin
                    if (d_done) begin
                        r_al <= {1'b0, w_alprod};
                        r_state <= S_PREP;
                    end
                end
                S_MUL: begin
                    r_prod <= w_prod;
                    r_ppi  <= r_pi;
                    r_pv   <= 1'b1;
                    r_pi   <= r_pi + 2'd1;
                    if (r_pv && !r_ps[r_ppi]) begin
                        if (r_prod < r_lov) r_lov <= r_prod;
                        if (r_prod > r_hiv) r_hiv <= r_prod;
                    end
                    if (r_pv && r_ppi == 2'd3) begin
                        if (w_a_zero || w_b_zero) begin
                            r_lo <= 1'b0;
                            r_hi <= 1'b0;
                            r_mn <= '0;
                            r_mx <= '0;
                            r_state <= S_FIN;
                        end else if ((r_in.a_open_low && r_in.a_open_high)
                                || (r_in.b_open_low && r_in.b_open_high)) begin
                            r_lo <= 1'b1;
                            r_hi <= 1'b1;
                            r_state <= S_PREP;
                        end else begin
                            r_lo <= (r_in.a_open_low && !w_b_np) || (r_in.b_open_low && !w_a_np)
                                 || (r_in.a_open_high && !w_b_nn) || (r_in.b_open_high && !w_a_nn);
                            r_hi <= (r_in.a_open_high && !w_b_np) || (r_in.b_open_high && !w_a_np)
                                 || (r_in.a_open_low && !w_b_nn) || (r_in.b_open_low && !w_a_nn);
                            r_mn <= (!r_ps[3] && r_prod < r_lov) ? r_prod : r_lov;
                            r_mx <= (!r_ps[3] && r_prod > r_hiv) ? r_prod : r_hiv;
                            r_state <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    // Unbounded ends read as zero; a bounded constant is not snapped.
                    if (r_lo) r_mn <= '0;
                    if (r_hi) r_mx <= '0;
                    if (r_lo || r_hi) begin
                        r_snap <= 1'b0;
                    end else begin
                        r_snap <= 1'b1;
                    end
                    if (!r_lo && !r_hi && r_mn == r_mx) begin
                        r_state <= S_FIN;
                    end else if (!r_lo) begin
                        r_dstart <= 1'b1;
                        r_state <= S_DMIN;
                    end else if (!r_hi) begin
                        r_dstart <= 1'b1;
                        r_state <= S_DMAX;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_DMIN: begin
                    if (d_done) begin
                        r_mn <= w_up;
                        if (!r_hi) begin
                            r_dstart <= 1'b1;
                            r_state <= S_DMAX;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_DMAX: begin
                    if (d_done) begin
                        r_mx <= w_dn;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_out.r_min <= r_mn;
                    r_out.r_max <= r_mx;
                    r_out.r_open_low <= r_lo;
                    r_out.r_open_high <= r_hi;
                    if (!r_lo && !r_hi && r_mn == r_mx && r_mn != 0
                            && (r_snap || r_in.mode != aia_pkg::MODE_MUL))
                        r_out.r_align <= w_m64[62:0];
                    else
                        r_out.r_align <= r_al;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_ch.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> bench/tb_aligned_interval_alu.sv
`timescale 1ns / 100ps

module tb_aligned_interval_alu;

    // The package names only the five defined operations; the three spare
    // encodings must still be exercised, so they get names here.
    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;

    localparam longint      I64_MAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      I64_MIN     = 64'sh8000_0000_0000_0000;
    localparam int          RANDOM_WORDS = 1750;
    localparam int          DRAIN_CYCLES = 300;
    localparam longint      CYCLE_LIMIT  = 3_000_000;

    // One operand or result range as the arithmetic sees it.
    typedef struct {
        bit                  open_lo;
        bit                  open_hi;
        longint              lo_bound;
        longint              hi_bound;
        longint unsigned     step;
    } t_span;

    logic i_clk;
    logic i_rst_n;

    aia_in_if  in_ch ();
    aia_out_if out_ch ();

    aligned_interval_alu u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    // Expected result ranges, oldest first.
    aia_pkg::t_out pending_ranges[$];
    int     mismatch_count;
    int     words_sent;
    int     ranges_checked;
    longint cycle_count;

    // Idle knobs for the two sides (percent), and a counted hold-off that
    // keeps the receiver stalled for a long stretch.
    int send_idle_pct;
    int recv_stall_pct;
    int recv_holdoff;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped: cycle limit reached with %0d ranges pending.",
                     pending_ranges.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Range arithmetic predictor.
    // ------------------------------------------------------------------

    function automatic longint unsigned gcd_u64(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic longint unsigned magnitude(longint v);
        return (v < 0) ? longint'(64'd0 - v) : v;
    endfunction

    // Division truncates toward zero, so the quotient needs a correction
    // only on one side of zero for each rounding direction.
    function automatic longint ceil_to(longint v, longint unsigned al);
        longint a;
        longint q;
        a = longint'(al);
        q = v / a;
        if (v % a == 0) return v;
        return (v >= 0) ? q * a + a : q * a;
    endfunction

    function automatic longint floor_to(longint v, longint unsigned al);
        longint a;
        longint q;
        a = longint'(al);
        q = v / a;
        if (v % a == 0) return v;
        return (v < 0) ? q * a - a : q * a;
    endfunction

    // Builds a result range: unbounded ends read as zero, bounded ends are
    // snapped to the alignment, and a single nonzero point takes its own
    // magnitude as alignment.
    function automatic t_span snap_span(bit olo, bit ohi, longint mn, longint mx,
                                        longint unsigned al);
        t_span r;
        r.open_lo  = olo;
        r.open_hi  = ohi;
        r.lo_bound = 0;
        r.hi_bound = 0;
        r.step     = al;
        if (olo && ohi) return r;
        if (olo) begin
            r.hi_bound = floor_to(mx, al);
            return r;
        end
        if (ohi) begin
            r.lo_bound = ceil_to(mn, al);
            return r;
        end
        if (mn == mx) begin
            r.lo_bound = mn;
            r.hi_bound = mx;
            if (mn != 0) r.step = magnitude(mn);
            return r;
        end
        r.lo_bound = ceil_to(mn, al);
        r.hi_bound = floor_to(mx, al);
        if (r.lo_bound == r.hi_bound && r.lo_bound != 0) r.step = magnitude(r.lo_bound);
        return r;
    endfunction

    function automatic bit never_positive(t_span x);
        return !x.open_hi && x.hi_bound <= 0;
    endfunction

    function automatic bit never_negative(t_span x);
        return !x.open_lo && x.lo_bound >= 0;
    endfunction

    function automatic bit is_zero_point(t_span x);
        return !x.open_lo && !x.open_hi && x.lo_bound == 0 && x.hi_bound == 0;
    endfunction

    function automatic t_span multiply_spans(t_span a, t_span b);
        longint unsigned al;
        longint          prod [4];
        bit              skip [4];
        longint          lo_v;
        longint          hi_v;
        bit              olo;
        bit              ohi;
        t_span           r;
        al   = a.step * b.step;
        lo_v = I64_MAX;
        hi_v = I64_MIN;
        if (is_zero_point(a) || is_zero_point(b)) begin
            r.open_lo  = 1'b0;
            r.open_hi  = 1'b0;
            r.lo_bound = 0;
            r.hi_bound = 0;
            r.step     = al;
            return r;
        end
        if ((a.open_lo && a.open_hi) || (b.open_lo && b.open_hi))
            return snap_span(1'b1, 1'b1, 0, 0, al);
        // An open end spreads to the result when the other operand has a
        // part whose sign pushes the product toward that end.
        olo = (a.open_lo && !never_positive(b)) || (b.open_lo && !never_positive(a)) ||
              (a.open_hi && !never_negative(b)) || (b.open_hi && !never_negative(a));
        ohi = (a.open_hi && !never_positive(b)) || (b.open_hi && !never_positive(a)) ||
              (a.open_lo && !never_negative(b)) || (b.open_lo && !never_negative(a));
        prod[0] = a.lo_bound * b.lo_bound; skip[0] = a.open_lo || b.open_lo;
        prod[1] = a.lo_bound * b.hi_bound; skip[1] = a.open_lo || b.open_hi;
        prod[2] = a.hi_bound * b.lo_bound; skip[2] = a.open_hi || b.open_lo;
        prod[3] = a.hi_bound * b.hi_bound; skip[3] = a.open_hi || b.open_hi;
        for (int i = 0; i < 4; i++) begin
            if (!skip[i]) begin
                if (prod[i] < lo_v) lo_v = prod[i];
                if (prod[i] > hi_v) hi_v = prod[i];
            end
        end
        return snap_span(olo, ohi, lo_v, hi_v, al);
    endfunction

    function automatic aia_pkg::t_out predict_range(aia_pkg::t_in w);
        t_span  a;
        t_span  b;
        t_span  r;
        bit     olo;
        bit     ohi;
        longint mn;
        longint mx;
        aia_pkg::t_out res;
        a.lo_bound = longint'(w.a_min);
        a.hi_bound = longint'(w.a_max);
        a.open_lo  = w.a_open_low;
        a.open_hi  = w.a_open_high;
        a.step     = (w.a_align == 0) ? 64'd1 : {33'd0, w.a_align};
        b.lo_bound = longint'(w.b_min);
        b.hi_bound = longint'(w.b_max);
        b.open_lo  = w.b_open_low;
        b.open_hi  = w.b_open_high;
        b.step     = (w.b_align == 0) ? 64'd1 : {33'd0, w.b_align};
        case (w.mode)
            aia_pkg::MODE_ADD: begin
                r = snap_span(a.open_lo || b.open_lo, a.open_hi || b.open_hi,
                              a.lo_bound + b.lo_bound, a.hi_bound + b.hi_bound,
                              gcd_u64(a.step, b.step));
            end
            aia_pkg::MODE_SUB: begin
                r = snap_span(a.open_lo || b.open_hi, a.open_hi || b.open_lo,
                              a.lo_bound - b.hi_bound, a.hi_bound - b.lo_bound,
                              gcd_u64(a.step, b.step));
            end
            aia_pkg::MODE_MUL: begin
                r = multiply_spans(a, b);
            end
            aia_pkg::MODE_UNI: begin
                // Union narrows here: larger min, smaller max, lcm step.
                olo = a.open_lo && b.open_lo;
                ohi = a.open_hi && b.open_hi;
                mn  = 0;
                mx  = 0;
                if (!olo)
                    mn = a.open_lo ? b.lo_bound : (b.open_lo ? a.lo_bound :
                         ((a.lo_bound > b.lo_bound) ? a.lo_bound : b.lo_bound));
                if (!ohi)
                    mx = a.open_hi ? b.hi_bound : (b.open_hi ? a.hi_bound :
                         ((a.hi_bound < b.hi_bound) ? a.hi_bound : b.hi_bound));
                r = snap_span(olo, ohi, mn, mx, a.step / gcd_u64(a.step, b.step) * b.step);
            end
            aia_pkg::MODE_INT: begin
                // Intersection widens to the hull with the gcd step.
                olo = a.open_lo || b.open_lo;
                ohi = a.open_hi || b.open_hi;
                mn  = olo ? 0 : ((a.lo_bound < b.lo_bound) ? a.lo_bound : b.lo_bound);
                mx  = ohi ? 0 : ((a.hi_bound > b.hi_bound) ? a.hi_bound : b.hi_bound);
                r = snap_span(olo, ohi, mn, mx, gcd_u64(a.step, b.step));
            end
            default: begin
                r = snap_span(1'b1, 1'b1, 0, 0, 64'd1);
            end
        endcase
        res.r_min       = r.lo_bound;
        res.r_max       = r.hi_bound;
        res.r_open_low  = r.open_lo;
        res.r_open_high = r.open_hi;
        res.r_align     = r.step[62:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender, receiver and result checker.
    // ------------------------------------------------------------------

    // Offers one word after an optional random gap and records the
    // expected range at the edge where the word is taken.
    task automatic send_word(aia_pkg::t_in w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data  = w;
        do @(posedge i_clk); while (!in_ch.ready);
        pending_ranges.push_back(predict_range(w));
        words_sent++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (recv_holdoff > 0) begin
            out_ch.ready = 1'b0;
            recv_holdoff = recv_holdoff - 1;
        end else begin
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        aia_pkg::t_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_ranges.size() == 0) begin
                $error("Result word arrived with no expected range pending.");
                mismatch_count++;
            end else begin
                want = pending_ranges.pop_front();
                ranges_checked++;
                if (out_ch.data.r_min !== want.r_min) begin
                    $error("r_min: expected %0d, got %0d", want.r_min, out_ch.data.r_min);
                    mismatch_count++;
                end
                if (out_ch.data.r_max !== want.r_max) begin
                    $error("r_max: expected %0d, got %0d", want.r_max, out_ch.data.r_max);
                    mismatch_count++;
                end
                if (out_ch.data.r_open_low !== want.r_open_low) begin
                    $error("r_open_low: expected %0d, got %0d",
                           want.r_open_low, out_ch.data.r_open_low);
                    mismatch_count++;
                end
                if (out_ch.data.r_open_high !== want.r_open_high) begin
                    $error("r_open_high: expected %0d, got %0d",
                           want.r_open_high, out_ch.data.r_open_high);
                    mismatch_count++;
                end
                if (out_ch.data.r_align !== want.r_align) begin
                    $error("r_align: expected %0d, got %0d", want.r_align, out_ch.data.r_align);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    function automatic aia_pkg::t_in make_word(logic [2:0] mode,
                                      int amin, int amax, bit alo, bit ahi, int aal,
                                      int bmin, int bmax, bit blo, bit bhi, int bal);
        aia_pkg::t_in w;
        w.mode        = mode;
        w.a_min       = amin;
        w.a_max       = amax;
        w.a_open_low  = alo;
        w.a_open_high = ahi;
        w.a_align     = aal[30:0];
        w.b_min       = bmin;
        w.b_max       = bmax;
        w.b_open_low  = blo;
        w.b_open_high = bhi;
        w.b_align     = bal[30:0];
        return w;
    endfunction

    // Bounds lean toward small values, where snapping and sign rules bite,
    // with extremes and fully random values mixed in.
    function automatic int random_bound();
        case ($urandom_range(7))
            0, 1, 2: return $urandom_range(80) - 40;
            3:       return $urandom_range(2000) - 1000;
            4:       return 32'h7FFF_FFFF - $urandom_range(3);
            5:       return 32'h8000_0000 + $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic int random_align();
        case ($urandom_range(9))
            0:       return 0;
            1:       return 1 << $urandom_range(30);
            2:       return $urandom & 32'h7FFF_FFFF;
            3:       return 32'h7FFF_FFFF - $urandom_range(2);
            default: return $urandom_range(16, 1);
        endcase
    endfunction

    function automatic aia_pkg::t_in random_word();
        aia_pkg::t_in w;
        int  lo;
        int  hi;
        int  r;
        r = $urandom_range(99);
        w.mode = (r < 6) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
        lo = random_bound();
        hi = random_bound();
        // Mostly well-ordered ranges; a few are left empty on purpose.
        if (lo > hi && $urandom_range(9) != 0) begin
            r = lo; lo = hi; hi = r;
        end
        w.a_min = lo;
        w.a_max = ($urandom_range(7) == 0) ? lo : hi;
        lo = random_bound();
        hi = random_bound();
        if (lo > hi && $urandom_range(9) != 0) begin
            r = lo; lo = hi; hi = r;
        end
        if ($urandom_range(11) == 0) begin
            lo = 0; hi = 0;
        end
        w.b_min       = lo;
        w.b_max       = ($urandom_range(7) == 0) ? lo : hi;
        w.a_open_low  = ($urandom_range(3) == 0);
        w.a_open_high = ($urandom_range(3) == 0);
        w.b_open_low  = ($urandom_range(3) == 0);
        w.b_open_high = ($urandom_range(3) == 0);
        w.a_align     = 31'(random_align());
        w.b_align     = 31'(random_align());
        return w;
    endfunction

    task automatic wait_all_delivered();
        while (pending_ranges.size() != 0) @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Extremes of every bound through add and subtract.
        send_word(make_word(aia_pkg::MODE_ADD, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1,
                            32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1));
        send_word(make_word(aia_pkg::MODE_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                            32'h7FFF_FFFE));
        send_word(make_word(aia_pkg::MODE_ADD, -7, 13, 0, 1, 4, 3, 9, 1, 0, 6));
        send_word(make_word(aia_pkg::MODE_SUB, -7, 13, 1, 0, 6, 3, 9, 0, 1, 9));
        // Zero alignment reads as one.
        send_word(make_word(aia_pkg::MODE_ADD, -5, 5, 0, 0, 0, 1, 2, 0, 0, 0));
        // Constant ranges take their magnitude as alignment.
        send_word(make_word(aia_pkg::MODE_ADD, -12, -12, 0, 0, 5, 0, 0, 0, 0, 3));
        send_word(make_word(aia_pkg::MODE_ADD, 0, 0, 0, 0, 5, 0, 0, 0, 0, 3));
        // Multiply: extremes, a zero operand, a fully open operand and the
        // sign rules for open ends.
        send_word(make_word(aia_pkg::MODE_MUL, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0,
                            32'h7FFF_FFFF));
        send_word(make_word(aia_pkg::MODE_MUL, 0, 0, 0, 0, 3, -4, 9, 1, 1, 5));
        send_word(make_word(aia_pkg::MODE_MUL, -3, 8, 1, 1, 2, 2, 9, 0, 0, 3));
        send_word(make_word(aia_pkg::MODE_MUL, 2, 5, 0, 1, 1, 3, 4, 0, 0, 1));
        send_word(make_word(aia_pkg::MODE_MUL, 2, 5, 0, 1, 1, -4, -3, 0, 0, 1));
        send_word(make_word(aia_pkg::MODE_MUL, 2, 5, 1, 0, 2, -4, 3, 0, 0, 1));
        send_word(make_word(aia_pkg::MODE_MUL, -6, 0, 1, 0, 1, 0, 7, 0, 1, 1));
        // Union narrows with lcm alignment; intersection widens with gcd.
        send_word(make_word(aia_pkg::MODE_UNI, -20, 30, 0, 0, 32'h7FFF_FFFF, -10, 40, 0, 0,
                            32'h7FFF_FFFE));
        send_word(make_word(aia_pkg::MODE_UNI, -20, 30, 1, 0, 4, -10, 40, 0, 1, 6));
        send_word(make_word(aia_pkg::MODE_UNI, -20, 30, 1, 1, 4, -10, 40, 1, 1, 6));
        send_word(make_word(aia_pkg::MODE_INT, -20, 30, 0, 0, 12, -10, 40, 0, 0, 18));
        send_word(make_word(aia_pkg::MODE_INT, -20, 30, 1, 0, 12, -10, 40, 0, 0, 18));
        // An empty range is not detected.
        send_word(make_word(aia_pkg::MODE_ADD, 9, -9, 0, 0, 2, 5, 1, 0, 0, 4));
        send_word(make_word(aia_pkg::MODE_INT, 9, -9, 0, 0, 2, 5, 1, 0, 0, 4));
        // Spare encodings give a fully open range.
        send_word(make_word(MODE_SPARE5, 1, 2, 0, 0, 1, 1, 2, 0, 0, 1));
        send_word(make_word(MODE_SPARE6, 1, 2, 0, 0, 1, 1, 2, 0, 0, 1));
        send_word(make_word(MODE_SPARE7, 1, 2, 0, 0, 1, 1, 2, 0, 0, 1));
        wait_all_delivered();
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_word(random_word());
    endtask

    // The receiver is held off long enough that the result register fills
    // and the input stalls while words keep being offered; the sender then
    // pauses until everything has drained.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        recv_holdoff = 600;
        repeat (4) send_word(random_word());
        wait_all_delivered();
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.data     = '0;
        out_ch.ready   = 1'b0;
        mismatch_count = 0;
        words_sent     = 0;
        ranges_checked = 0;
        cycle_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_holdoff   = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(RANDOM_WORDS / 4, 0, 0);
        test_backpressure();
        test_random(RANDOM_WORDS / 4, 66, 0);
        test_random(RANDOM_WORDS / 4, 0, 66);
        test_random(RANDOM_WORDS / 4, 11, 11);

        wait_all_delivered();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_ranges.size() != 0) begin
            $error("%0d expected ranges never arrived.", pending_ranges.size());
            mismatch_count++;
        end

        $display("Covered all five operations, spare modes, open ends and alignment cases.");
        $display("Sent %0d words, checked %0d ranges, across idle, stall and hold-off phases.",
                 words_sent, ranges_checked);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
